// ===== hdl/gcd_lcm_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit: next-cycle check failed");

`endif

// ===== hdl/gcl_pkg.sv =====
`default_nettype none

package gcl_pkg;

  localparam int unsigned OP_W   = 16;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned CNT_W  = $clog2(OP_W + 1);
  localparam int unsigned PC_W   = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic [15:0] first_value;
    logic [15:0] second_value;
  } in_t;

  typedef struct packed {
    logic [15:0] gcd_result;
    logic [31:0] lcm_result;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE_BOTH,
    OP_HALVE_X,
    OP_HALVE_Y,
    OP_SWAP_SUB,
    OP_FIX_GCD,
    OP_DIV_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_ZERO_RES,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_ANY_ZERO,
    COND_EITHER_ODD,
    COND_X_ODD,
    COND_Y_ODD,
    COND_X_EQ_Y,
    COND_CNT_ZERO,
    COND_OUT_FULL
  } cond_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_HOLD,
    SEQ_BACK,
    SEQ_START
  } seq_e;

  // A taken condition jumps to target and suppresses the op.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    seq_e  seq;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic any_zero;
    logic either_odd;
    logic x_odd;
    logic y_odd;
    logic x_eq_y;
    logic cnt_zero;
    logic out_full;
  } flags_t;

  localparam pc_t STEP_WAIT     = PC_W'(0);
  localparam pc_t STEP_ZCHK     = PC_W'(1);
  localparam pc_t STEP_TWOS     = PC_W'(2);
  localparam pc_t STEP_ODD_X    = PC_W'(3);
  localparam pc_t STEP_ODD_Y    = PC_W'(4);
  localparam pc_t STEP_SUB      = PC_W'(5);
  localparam pc_t STEP_FIX      = PC_W'(6);
  localparam pc_t STEP_DIV      = PC_W'(7);
  localparam pc_t STEP_MUL_INIT = PC_W'(8);
  localparam pc_t STEP_MUL      = PC_W'(9);
  localparam pc_t STEP_ZERO     = PC_W'(10);
  localparam pc_t STEP_EMIT     = PC_W'(11);

endpackage

`default_nettype wire

// ===== hdl/gcd_lcm_unit.sv =====
// GCD and LCM of two unsigned 16-bit operands, one result per input transfer.
// A microcoded sequencer steps a small datapath: binary GCD by halving and
// subtracting, then first/gcd by restoring division (one quotient bit a cycle)
// and the LCM by shift-add multiply with the second operand (one bit a cycle).
// An operand of zero skips the GCD loop, the divide and the multiply
// (gcd is the other operand, lcm is 0). One item is in work at a time;
// in_ready_o is high only while the sequencer waits at its first step, and
// the result register lets the next item start while a result is pending.
`default_nettype none

module gcd_lcm_unit (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          in_valid_i,
  output var logic          in_ready_o,
  input  var gcl_pkg::in_t  in_data_i,
  output var logic          out_valid_o,
  input  var logic          out_ready_i,
  output var gcl_pkg::out_t out_data_o
);

  gcl_pkg::pc_t    pc;
  gcl_pkg::ucode_t word;
  gcl_pkg::op_e    op;
  gcl_pkg::flags_t flags;

  gcl_ucode u_ucode (
    .pc_i   (pc),
    .word_o (word)
  );

  gcl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .word_i  (word),
    .flags_i (flags),
    .pc_o    (pc),
    .op_o    (op),
    .idle_o  (in_ready_o)
  );

  gcl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .flags_o     (flags)
  );

endmodule

`default_nettype wire

// ===== hdl/gcl_ucode.sv =====
`default_nettype none

module gcl_ucode (
  input  var gcl_pkg::pc_t    pc_i,
  output var gcl_pkg::ucode_t word_o
);

  always_comb begin
    unique case (pc_i)
      gcl_pkg::STEP_WAIT: begin
        word_o = '{gcl_pkg::OP_LOAD, gcl_pkg::COND_NO_START, gcl_pkg::SEQ_NEXT,
                   gcl_pkg::STEP_WAIT};
      end
      gcl_pkg::STEP_ZCHK: begin
        word_o = '{gcl_pkg::OP_NOP, gcl_pkg::COND_ANY_ZERO, gcl_pkg::SEQ_NEXT,
                   gcl_pkg::STEP_ZERO};
      end
      gcl_pkg::STEP_TWOS: begin
        word_o = '{gcl_pkg::OP_HALVE_BOTH, gcl_pkg::COND_EITHER_ODD, gcl_pkg::SEQ_HOLD,
                   gcl_pkg::STEP_ODD_X};
      end
      gcl_pkg::STEP_ODD_X: begin
        word_o = '{gcl_pkg::OP_HALVE_X, gcl_pkg::COND_X_ODD, gcl_pkg::SEQ_HOLD,
                   gcl_pkg::STEP_ODD_Y};
      end
      gcl_pkg::STEP_ODD_Y: begin
        word_o = '{gcl_pkg::OP_HALVE_Y, gcl_pkg::COND_Y_ODD, gcl_pkg::SEQ_HOLD,
                   gcl_pkg::STEP_SUB};
      end
      gcl_pkg::STEP_SUB: begin
        word_o = '{gcl_pkg::OP_SWAP_SUB, gcl_pkg::COND_X_EQ_Y, gcl_pkg::SEQ_BACK,
                   gcl_pkg::STEP_FIX};
      end
      gcl_pkg::STEP_FIX: begin
        word_o = '{gcl_pkg::OP_FIX_GCD, gcl_pkg::COND_NEVER, gcl_pkg::SEQ_NEXT,
                   gcl_pkg::STEP_WAIT};
      end
      gcl_pkg::STEP_DIV: begin
        word_o = '{gcl_pkg::OP_DIV_STEP, gcl_pkg::COND_CNT_ZERO, gcl_pkg::SEQ_HOLD,
                   gcl_pkg::STEP_MUL_INIT};
      end
      gcl_pkg::STEP_MUL_INIT: begin
        word_o = '{gcl_pkg::OP_MUL_INIT, gcl_pkg::COND_NEVER, gcl_pkg::SEQ_NEXT,
                   gcl_pkg::STEP_WAIT};
      end
      gcl_pkg::STEP_MUL: begin
        word_o = '{gcl_pkg::OP_MUL_STEP, gcl_pkg::COND_CNT_ZERO, gcl_pkg::SEQ_HOLD,
                   gcl_pkg::STEP_EMIT};
      end
      gcl_pkg::STEP_ZERO: begin
        word_o = '{gcl_pkg::OP_ZERO_RES, gcl_pkg::COND_NEVER, gcl_pkg::SEQ_NEXT,
                   gcl_pkg::STEP_WAIT};
      end
      gcl_pkg::STEP_EMIT: begin
        word_o = '{gcl_pkg::OP_EMIT, gcl_pkg::COND_OUT_FULL, gcl_pkg::SEQ_START,
                   gcl_pkg::STEP_EMIT};
      end
      default: begin
        word_o = '{gcl_pkg::OP_NOP, gcl_pkg::COND_ALWAYS, gcl_pkg::SEQ_START,
                   gcl_pkg::STEP_WAIT};
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gcl_seq.sv =====
`default_nettype none

module gcl_seq (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var gcl_pkg::ucode_t word_i,
  input  var gcl_pkg::flags_t flags_i,
  output var gcl_pkg::pc_t    pc_o,
  output var gcl_pkg::op_e    op_o,
  output var logic            idle_o
);

  gcl_pkg::pc_t pc_q, pc_d;
  logic         taken;

  always_comb begin
    unique case (word_i.cond)
      gcl_pkg::COND_NEVER:      taken = 1'b0;
      gcl_pkg::COND_ALWAYS:     taken = 1'b1;
      gcl_pkg::COND_NO_START:   taken = !flags_i.start;
      gcl_pkg::COND_ANY_ZERO:   taken = flags_i.any_zero;
      gcl_pkg::COND_EITHER_ODD: taken = flags_i.either_odd;
      gcl_pkg::COND_X_ODD:      taken = flags_i.x_odd;
      gcl_pkg::COND_Y_ODD:      taken = flags_i.y_odd;
      gcl_pkg::COND_X_EQ_Y:     taken = flags_i.x_eq_y;
      gcl_pkg::COND_CNT_ZERO:   taken = flags_i.cnt_zero;
      gcl_pkg::COND_OUT_FULL:   taken = flags_i.out_full;
      default:                  taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_d = word_i.target;
    end else begin
      unique case (word_i.seq)
        gcl_pkg::SEQ_NEXT:  pc_d = pc_q + 1'b1;
        gcl_pkg::SEQ_HOLD:  pc_d = pc_q;
        gcl_pkg::SEQ_BACK:  pc_d = pc_q - 1'b1;
        gcl_pkg::SEQ_START: pc_d = gcl_pkg::STEP_WAIT;
        default:            pc_d = gcl_pkg::STEP_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gcl_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o   = taken ? gcl_pkg::OP_NOP : word_i.op;
  assign pc_o   = pc_q;
  assign idle_o = (pc_q == gcl_pkg::STEP_WAIT);

endmodule

`default_nettype wire

// ===== hdl/gcl_dp.sv =====
`default_nettype none

module gcl_dp (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var gcl_pkg::op_e    op_i,
  input  var logic            in_valid_i,
  input  var gcl_pkg::in_t    in_data_i,
  input  var logic            out_ready_i,
  output var logic            out_valid_o,
  output var gcl_pkg::out_t   out_data_o,
  output var gcl_pkg::flags_t flags_o
);

  localparam int unsigned W = gcl_pkg::OP_W;
  localparam int unsigned P = gcl_pkg::PROD_W;
  localparam int unsigned C = gcl_pkg::CNT_W;

  logic [W-1:0]  a_q, a_d, b_q, b_d, x_q, x_d, y_q, y_d, rem_q, rem_d;
  logic [C-1:0]  sh_q, sh_d, cnt_q, cnt_d;
  logic [P-1:0]  prod_q, prod_d;
  gcl_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [W:0]    trial, diff, sum;

  assign trial = {rem_q, a_q[W-1]};
  assign diff  = trial - {1'b0, x_q};
  assign sum   = {1'b0, prod_q[P-1:W]} + (prod_q[0] ? {1'b0, b_q} : '0);

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    y_d         = y_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (op_i)
      gcl_pkg::OP_NOP: begin
      end
      gcl_pkg::OP_LOAD: begin
        a_d  = W'(in_data_i.first_value);
        b_d  = W'(in_data_i.second_value);
        x_d  = W'(in_data_i.first_value);
        y_d  = W'(in_data_i.second_value);
        sh_d = '0;
      end
      gcl_pkg::OP_HALVE_BOTH: begin
        x_d  = x_q >> 1;
        y_d  = y_q >> 1;
        sh_d = sh_q + 1'b1;
      end
      gcl_pkg::OP_HALVE_X: begin
        x_d = x_q >> 1;
      end
      gcl_pkg::OP_HALVE_Y: begin
        y_d = y_q >> 1;
      end
      gcl_pkg::OP_SWAP_SUB: begin
        if (x_q > y_q) begin
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      gcl_pkg::OP_FIX_GCD: begin
        x_d   = x_q << sh_q;
        rem_d = '0;
        cnt_d = C'(W);
      end
      gcl_pkg::OP_DIV_STEP: begin
        if (!diff[W]) begin
          rem_d = diff[W-1:0];
          a_d   = {a_q[W-2:0], 1'b1};
        end else begin
          rem_d = trial[W-1:0];
          a_d   = {a_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      gcl_pkg::OP_MUL_INIT: begin
        prod_d = P'(a_q);
        cnt_d  = C'(W);
      end
      gcl_pkg::OP_MUL_STEP: begin
        prod_d = {sum, prod_q[W-1:1]};
        cnt_d  = cnt_q - 1'b1;
      end
      gcl_pkg::OP_ZERO_RES: begin
        x_d    = a_q | b_q;
        prod_d = '0;
      end
      gcl_pkg::OP_EMIT: begin
        out_d.gcd_result = 16'(x_q);
        out_d.lcm_result = 32'(prod_q);
        out_valid_d      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign flags_o.start      = in_valid_i;
  assign flags_o.any_zero   = (a_q == '0) || (b_q == '0);
  assign flags_o.either_odd = x_q[0] | y_q[0];
  assign flags_o.x_odd      = x_q[0];
  assign flags_o.y_odd      = y_q[0];
  assign flags_o.x_eq_y     = (x_q == y_q);
  assign flags_o.cnt_zero   = (cnt_q == '0);
  assign flags_o.out_full   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/gcl_checker.sv =====
`default_nettype none

`include "gcd_lcm_unit_defines.svh"

module gcl_checker (
  input var logic          clk_i,
  input var logic          rst_ni,
  input var logic          in_valid_i,
  input var logic          in_ready_i,
  input var logic          out_valid_i,
  input var logic          out_ready_i,
  input var gcl_pkg::out_t out_data_i
);

  `GCL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_data_i))
  `GCL_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `GCL_ASSERT_IMP(a_lcm_ge_gcd, clk_i, rst_ni,
                  out_valid_i && (out_data_i.lcm_result != '0),
                  (out_data_i.gcd_result != '0) &&
                  (32'(out_data_i.gcd_result) <= out_data_i.lcm_result))

endmodule

bind gcd_lcm_unit gcl_checker u_gcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

// ===== sim/gcd_lcm_unit_tb.sv =====
`timescale 1ns / 100ps

module gcd_lcm_unit_tb;

  localparam int unsigned RANDOM_PAIRS = 950;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned HOLD_AT      = 250;
  localparam int unsigned PAUSE_AT     = 700;
  localparam int unsigned NUM_ROWS     = 22;
  localparam int unsigned FIFO_DEPTH   = 1024;

  typedef struct packed {
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        known;
    logic [15:0] gcd_result;
    logic [31:0] lcm_result;
  } pair_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  gcl_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  gcl_pkg::out_t out_data_o;

  gcl_pkg::out_t expected_fifo [FIFO_DEPTH];
  logic [9:0]    fifo_wr        = '0;
  logic [9:0]    fifo_rd        = '0;
  int unsigned   error_count    = 0;
  int unsigned   results_seen   = 0;
  int unsigned   cycle_count    = 0;
  bit            long_hold_done = 1'b0;

  pair_row_t directed_rows [NUM_ROWS] = '{
    '{16'd0,     16'd0,     1'b1, 16'd0,     32'd0},
    '{16'd0,     16'd5,     1'b1, 16'd5,     32'd0},
    '{16'd7,     16'd0,     1'b1, 16'd7,     32'd0},
    '{16'd0,     16'd65535, 1'b1, 16'd65535, 32'd0},
    '{16'd1,     16'd1,     1'b1, 16'd1,     32'd1},
    '{16'd65535, 16'd65535, 1'b1, 16'd65535, 32'd65535},
    '{16'd65535, 16'd1,     1'b1, 16'd1,     32'd65535},
    '{16'd1,     16'd65535, 1'b1, 16'd1,     32'd65535},
    '{16'd65535, 16'd65534, 1'b1, 16'd1,     32'd4294770690},
    '{16'd65521, 16'd65519, 1'b1, 16'd1,     32'd4292870399},
    '{16'd32768, 16'd32768, 1'b1, 16'd32768, 32'd32768},
    '{16'd32768, 16'd1,     1'b1, 16'd1,     32'd32768},
    '{16'd32768, 16'd16384, 1'b1, 16'd16384, 32'd32768},
    '{16'd1,     16'd32768, 1'b1, 16'd1,     32'd32768},
    '{16'd12,    16'd18,    1'b0, 16'd0,     32'd0},
    '{16'd48,    16'd180,   1'b0, 16'd0,     32'd0},
    '{16'd65534, 16'd32767, 1'b0, 16'd0,     32'd0},
    '{16'd43690, 16'd21845, 1'b0, 16'd0,     32'd0},
    '{16'd21845, 16'd43690, 1'b0, 16'd0,     32'd0},
    '{16'd1024,  16'd96,    1'b0, 16'd0,     32'd0},
    '{16'd255,   16'd257,   1'b0, 16'd0,     32'd0},
    '{16'd60060, 16'd30030, 1'b0, 16'd0,     32'd0}
  };

  gcd_lcm_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic gcl_pkg::out_t gcd_lcm_of(input gcl_pkg::in_t operands);
    gcl_pkg::out_t res;
    logic [15:0]   x;
    logic [15:0]   y;
    logic [15:0]   t;
    int unsigned   twos;
    x    = operands.first_value;
    y    = operands.second_value;
    twos = 0;
    res  = '0;
    if (x == 16'd0) begin
      res.gcd_result = y;
    end else if (y == 16'd0) begin
      res.gcd_result = x;
    end else begin
      while (x[0] == 1'b0 && y[0] == 1'b0) begin
        x = x >> 1;
        y = y >> 1;
        twos++;
      end
      while (x[0] == 1'b0) x = x >> 1;
      while (y != 16'd0) begin
        while (y[0] == 1'b0) y = y >> 1;
        if (x > y) begin
          t = x;
          x = y;
          y = t;
        end
        y = y - x;
      end
      res.gcd_result = x << twos;
      res.lcm_result = 32'(operands.first_value / res.gcd_result)
                       * 32'(operands.second_value);
    end
    return res;
  endfunction

  function automatic gcl_pkg::in_t draw_operand_pair();
    gcl_pkg::in_t pair;
    logic [15:0]  factor;
    int unsigned  mode;
    mode = $urandom_range(0, 9);
    pair.first_value  = 16'($urandom());
    pair.second_value = 16'($urandom());
    case (mode)
      3, 4: begin
        factor = 16'($urandom_range(1, 4095));
        pair.first_value  = 16'(factor * $urandom_range(1, 65535 / factor));
        pair.second_value = 16'(factor * $urandom_range(1, 65535 / factor));
      end
      5: begin
        pair.first_value  = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
        pair.second_value = 16'($urandom_range(1, 255) << $urandom_range(0, 8));
      end
      6: begin
        pair.second_value = pair.first_value >> $urandom_range(0, 4);
        if (pair.second_value == 16'd0) pair.second_value = pair.first_value;
      end
      7: begin
        pair.first_value  = 16'($urandom_range(1, 32));
        pair.second_value = 16'($urandom_range(1, 32));
      end
      8: begin
        pair.first_value  = 16'(65535 - $urandom_range(0, 300));
        pair.second_value = 16'(65535 - $urandom_range(0, 300));
      end
      9: begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) pair.first_value = '0;
          else pair.second_value = '0;
        end
      end
      default: ;
    endcase
    return pair;
  endfunction

  task automatic send_operands(input gcl_pkg::in_t operands,
                               input gcl_pkg::out_t expected_result,
                               input int unsigned gap);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= operands;
    do @(posedge clk_i); while (!in_ready_o);
    expected_fifo[fifo_wr] = expected_result;
    fifo_wr = fifo_wr + 1'b1;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    gcl_pkg::in_t  operands;
    gcl_pkg::out_t expected_result;
    int unsigned   gap;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NUM_ROWS; i++) begin
      operands.first_value  = directed_rows[i].first_value;
      operands.second_value = directed_rows[i].second_value;
      if (directed_rows[i].known) begin
        expected_result.gcd_result = directed_rows[i].gcd_result;
        expected_result.lcm_result = directed_rows[i].lcm_result;
      end else begin
        expected_result = gcd_lcm_of(operands);
      end
      send_operands(operands, expected_result, $urandom_range(0, 19));
    end
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == PAUSE_AT) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (fifo_wr != fifo_rd) @(posedge clk_i);
      end
      operands = draw_operand_pair();
      gap = ((i / 120) % 3 == 1) ? 0 : $urandom_range(0, 19);
      send_operands(operands, gcd_lcm_of(operands), gap);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (fifo_wr != fifo_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stall = ((results_seen / 80) % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    gcl_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (fifo_wr == fifo_rd) begin
        $display("%0t: unexpected transfer gcd %0d lcm %0d", $time,
                 out_data_o.gcd_result, out_data_o.lcm_result);
        error_count++;
      end else begin
        want = expected_fifo[fifo_rd];
        fifo_rd = fifo_rd + 1'b1;
        if (out_data_o.gcd_result !== want.gcd_result) begin
          $display("%0t: gcd_result expected %0d actual %0d", $time,
                   want.gcd_result, out_data_o.gcd_result);
          error_count++;
        end
        if (out_data_o.lcm_result !== want.lcm_result) begin
          $display("%0t: lcm_result expected %0d actual %0d", $time,
                   want.lcm_result, out_data_o.lcm_result);
          error_count++;
        end
      end
    end
  end

endmodule
